// File: hdl/modinv_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Widths and derived constants shared by the interfaces and the datapath.
// ----------------------------------------------------------------------------
package modinv_pkg;

    // Operand width of value, modulus and inverse.
    localparam int WIDTH = 16;

    // Bits of the per-bit division step counter.
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [WIDTH:0]   wide_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

// File: hdl/modinv_in_if.sv
// ----------------------------------------------------------------------------
// Modular inverse operand channel
// Valid/ready channel that carries one value and modulus pair per beat.
// ----------------------------------------------------------------------------
interface modinv_in_if;
    import modinv_pkg::*;

    logic  valid;
    logic  ready;
    word_t value;
    word_t modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

// File: hdl/modinv_out_if.sv
// ----------------------------------------------------------------------------
// Modular inverse result channel
// Valid/ready channel that carries one inverse and its existence flag per beat.
// ----------------------------------------------------------------------------
interface modinv_out_if;
    import modinv_pkg::*;

    logic  valid;
    logic  ready;
    word_t inverse;
    logic  has_inverse;

    modport source (output valid, output inverse, output has_inverse, input ready);
    modport sink   (input valid, input inverse, input has_inverse, output ready);
endinterface

// File: hdl/modular_inverse.sv
// ----------------------------------------------------------------------------
// Modular inverse
// Extended Euclidean inverse of a value modulo a modulus, one shared
// shift-subtract unit driven by a small sequencer.
// ----------------------------------------------------------------------------
// One operand beat gives exactly one result beat. The inverse comes back
// reduced into 0..modulus-1 with has_inverse set; when the value and the
// modulus are not coprime, or the modulus is below two, the block returns
// zero with has_inverse clear. The block works on one beat at a time and
// holds operands.ready low while busy. Each Euclid round is a check state,
// the restoring divider (one quotient bit per cycle, with the quotient times
// the current coefficient built alongside by shift-and-add), and an update
// state; for 16-bit operands an item takes at most about 24 rounds. A
// finished result sits in the output register until it is taken; the operand
// side opens again as soon as the result is loaded there.
// ----------------------------------------------------------------------------
module modular_inverse (
    input  logic clk,
    input  logic rst_n,
    modinv_in_if.sink    operands,
    modinv_out_if.source result
);
    import modinv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Euclid state: remainders, coefficient magnitudes and the sign of the
    // current coefficient. Successive coefficients alternate in sign.
    word_t mod_reg;
    word_t r_prev_reg;
    word_t r_cur_reg;
    word_t m_prev_reg;
    word_t m_cur_reg;
    logic  neg_reg;

    // Divider state: partial remainder, dividend shifting out MSB first, and
    // the running product quotient * m_cur.
    word_t rem_reg;
    word_t div_reg;
    word_t acc_reg;
    cnt_t  cnt_reg;

    // Final answer waiting for the output register.
    word_t ans_reg;
    logic  ans_ok_reg;

    // Output register.
    logic  out_valid_reg;
    word_t out_inv_reg;
    logic  out_ok_reg;

    // Shared divider step.
    wide_t trial;
    wide_t trial_diff;
    logic  ge;
    word_t rem_next;
    word_t acc_shift;
    word_t acc_next;

    // Final reduction.
    word_t red;
    word_t inv_next;

    always_comb
    begin
        trial      = {rem_reg, div_reg[WIDTH-1]};
        trial_diff = trial - {1'b0, r_cur_reg};
        ge         = (trial >= {1'b0, r_cur_reg});
        rem_next   = ge ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
        acc_shift  = {acc_reg[WIDTH-2:0], 1'b0};
        acc_next   = ge ? (acc_shift + m_cur_reg) : acc_shift;
    end

    // The coefficient magnitude never exceeds the modulus, so one compare
    // reduces it; a negative coefficient then folds to modulus - magnitude.
    always_comb
    begin
        red      = (m_cur_reg == mod_reg) ? '0 : m_cur_reg;
        inv_next = (neg_reg && (red != '0)) ? (mod_reg - red) : red;
    end

    assign operands.ready     = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.inverse     = out_inv_reg;
    assign result.has_inverse = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the finish state the output register is reloaded instead.
            if (out_valid_reg && result.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (operands.valid)
                    begin
                        mod_reg    <= operands.modulus;
                        r_prev_reg <= operands.modulus;
                        r_cur_reg  <= operands.value;
                        m_prev_reg <= '0;
                        m_cur_reg  <= word_t'(1);
                        neg_reg    <= 1'b0;
                        // A modulus of zero or one has no inverse at all.
                        if (operands.modulus < word_t'(2))
                        begin
                            ans_reg    <= '0;
                            ans_ok_reg <= 1'b0;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK:
                begin
                    if (r_cur_reg == '0)
                    begin
                        // The gcd is above one.
                        ans_reg    <= '0;
                        ans_ok_reg <= 1'b0;
                        state_reg  <= ST_FINISH;
                    end
                    else if (r_cur_reg == word_t'(1))
                    begin
                        state_reg <= ST_REDUCE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        div_reg   <= r_prev_reg;
                        acc_reg   <= '0;
                        cnt_reg   <= cnt_t'(WIDTH - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    div_reg <= {div_reg[WIDTH-2:0], 1'b0};
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg - cnt_t'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end

                ST_UPDATE:
                begin
                    r_prev_reg <= r_cur_reg;
                    r_cur_reg  <= rem_reg;
                    m_prev_reg <= m_cur_reg;
                    m_cur_reg  <= m_prev_reg + acc_reg;
                    neg_reg    <= ~neg_reg;
                    state_reg  <= ST_CHECK;
                end

                ST_REDUCE:
                begin
                    ans_reg    <= inv_next;
                    ans_ok_reg <= 1'b1;
                    state_reg  <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_inv_reg   <= ans_reg;
                        out_ok_reg    <= ans_ok_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/modular_inverse_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Drives value/modulus beats into the block and checks every result beat
// against an extended Euclid predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
import modinv_pkg::*;

class inverse_scoreboard;
    word_t expected_inverses[$];
    logic  expected_flags[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    // Extended Euclid on (modulus, value). Coefficients are kept as a
    // magnitude plus a sign; the sign flips on every round.
    function void solve_inverse(input word_t value, input word_t modulus,
                                output word_t inverse, output logic has_inverse);
        logic [2*WIDTH-1:0] r_prev, r_cur, r_next;
        logic [2*WIDTH-1:0] m_prev, m_cur, m_next;
        logic [2*WIDTH-1:0] quot, reduced;
        bit                 negative;
        r_prev      = (2*WIDTH)'(modulus);
        r_cur       = (2*WIDTH)'(value);
        m_prev      = 0;
        m_cur       = 1;
        negative    = 0;
        inverse     = '0;
        has_inverse = 1'b0;
        if (modulus < word_t'(2))
            return;
        while (r_cur > 1)
        begin
            quot     = r_prev / r_cur;
            r_next   = r_prev - quot * r_cur;
            m_next   = m_prev + quot * m_cur;
            r_prev   = r_cur;
            r_cur    = r_next;
            m_prev   = m_cur;
            m_cur    = m_next;
            negative = !negative;
        end
        if (r_cur == 0)
            return;
        reduced = m_cur % (2*WIDTH)'(modulus);
        if (negative && reduced != 0)
            reduced = (2*WIDTH)'(modulus) - reduced;
        inverse     = reduced[WIDTH-1:0];
        has_inverse = 1'b1;
    endfunction

    function void note_operands(word_t value, word_t modulus);
        word_t inverse;
        logic  has_inverse;
        solve_inverse(value, modulus, inverse, has_inverse);
        expected_inverses.push_back(inverse);
        expected_flags.push_back(has_inverse);
    endfunction

    function void check_result(word_t inverse, logic has_inverse);
        word_t want_inverse;
        logic  want_flag;
        if (expected_inverses.size() == 0)
        begin
            $error("unexpected result beat: inverse %0d, has_inverse %0d",
                   inverse, has_inverse);
            errors++;
            return;
        end
        want_inverse = expected_inverses.pop_front();
        want_flag    = expected_flags.pop_front();
        if (inverse !== want_inverse)
        begin
            $error("inverse: expected %0d, actual %0d", want_inverse, inverse);
            errors++;
        end
        if (has_inverse !== want_flag)
        begin
            $error("has_inverse: expected %0d, actual %0d", want_flag, has_inverse);
            errors++;
        end
    endfunction

    function int pending_count();
        return expected_inverses.size();
    endfunction
endclass

module modular_inverse_test;

    // 1500-odd items at the worst item time plus sender gaps, receiver stalls and
    // the long hold-off stay well under this.
    localparam int LIMIT_CYCLES   = 4_000_000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int DRAIN_CYCLES   = 500;
    localparam int HOLD_CYCLES    = 3000;
    localparam int HOLD_AFTER     = 200;

    logic clk;
    logic rst_n;

    modinv_in_if  operands_if();
    modinv_out_if result_if();

    modular_inverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if)
    );

    inverse_scoreboard sb;

    // Sender burst state: a burst runs back to back, then a random gap follows.
    int  burst_left;
    bit  sender_idles;

    // Receiver state: a step counter, the stall mode and pattern, and one long
    // hold-off that is taken once enough results have come back.
    int          rx_cycle;
    int          rx_mode;
    logic [31:0] rx_pattern;
    int          hold_left;
    bit          hold_taken;
    int          results_seen;
    longint      cycle_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("** modular_inverse: FAILED **");
                $finish;
            end
        end
    end

    // Offer one operand beat, wait for it to be taken, record the prediction,
    // then decide the idle gap before the next beat. With no gap, valid simply
    // stays high into the next beat.
    task automatic send_operands(input word_t value, input word_t modulus);
        int gap;
        @(negedge clk);
        operands_if.valid   <= 1'b1;
        operands_if.value   <= value;
        operands_if.modulus <= modulus;
        @(posedge clk);
        while (!operands_if.ready)
            @(posedge clk);
        sb.note_operands(value, modulus);
        gap = 0;
        if (sender_idles)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap        = $urandom_range(1, 24);
                burst_left = $urandom_range(0, 7);
            end
        end
        if (gap > 0)
        begin
            @(negedge clk);
            operands_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Random operand pairs, with shared factors, exact multiples, values above
    // the modulus and out-of-range moduli mixed in.
    task automatic pick_operands(output word_t value, output word_t modulus);
        int m;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                modulus = word_t'($urandom_range(2, 65535));
                value   = word_t'($urandom_range(0, 65535));
            end
            3, 4:
            begin
                m       = $urandom_range(2, 65535);
                modulus = word_t'(m);
                value   = word_t'($urandom_range(1, m - 1));
            end
            5:
            begin
                modulus = word_t'($urandom_range(2, 64));
                value   = word_t'($urandom_range(0, 65535));
            end
            6:
            begin
                m       = $urandom_range(2, 64);
                modulus = word_t'(m);
                value   = word_t'($urandom_range(0, m - 1));
            end
            7:
            begin
                // Exact multiple of the modulus, zero included.
                m       = $urandom_range(2, 255);
                modulus = word_t'(m);
                value   = word_t'(m * $urandom_range(0, 65535 / m));
            end
            8:
            begin
                modulus = word_t'($urandom_range(2, 65535));
                case ($urandom_range(0, 2))
                    0:       value = 16'd0;
                    1:       value = 16'd1;
                    default: value = 16'hFFFF;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    modulus = word_t'($urandom_range(0, 1));
                else
                    modulus = word_t'(16'hFFFF - $urandom_range(0, 15));
                value = word_t'($urandom_range(0, 65535));
            end
        endcase
    endtask

    // Receiver: ready changes at the falling edge only, one assignment a step.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (!hold_taken && results_seen >= HOLD_AFTER)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (rx_cycle % 128 == 0)
            begin
                rx_mode    = $urandom_range(0, 2);
                rx_pattern = $urandom;
            end
            case (rx_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= rx_pattern[rx_cycle[4:0]];
                default: result_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Every accepted result beat goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            sb.check_result(result_if.inverse, result_if.has_inverse);
            results_seen++;
        end
    end

    initial
    begin
        word_t value;
        word_t modulus;
        sb                  = new();
        clk                 = 1'b0;
        rst_n               = 1'b0;
        operands_if.valid   = 1'b0;
        operands_if.value   = '0;
        operands_if.modulus = '0;
        result_if.ready     = 1'b0;
        rx_cycle            = 0;
        rx_mode             = 0;
        rx_pattern          = 32'hFFFF_FFFF;
        hold_left           = 0;
        hold_taken          = 1'b0;
        results_seen        = 0;
        burst_left          = 0;
        sender_idles        = 1'b1;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: field extremes, no-inverse cases, value above the
        // modulus, exact multiples, moduli below two and a long Fibonacci run.
        send_operands(16'd0,     16'd7);
        send_operands(16'd1,     16'd2);
        send_operands(16'd1,     16'd65535);
        send_operands(16'd65535, 16'd65535);
        send_operands(16'd65534, 16'd65535);
        send_operands(16'd65535, 16'd65534);
        send_operands(16'd3,     16'd7);
        send_operands(16'd7,     16'd3);
        send_operands(16'd14,    16'd7);
        send_operands(16'd0,     16'd65535);
        send_operands(16'd2,     16'd65535);
        send_operands(16'd6,     16'd9);
        send_operands(16'd5,     16'd0);
        send_operands(16'd5,     16'd1);
        send_operands(16'd0,     16'd0);
        send_operands(16'd65535, 16'd0);
        send_operands(16'd65535, 16'd1);
        send_operands(16'd28657, 16'd46368);
        send_operands(16'd46368, 16'd28657);
        send_operands(16'd32768, 16'd65535);
        send_operands(16'd255,   16'd256);
        send_operands(16'd40503, 16'd65521);
        send_operands(16'd65520, 16'd65521);

        // Random part. Every 500 items the sender runs 100 beats with no gaps.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_idles = (i % 500) >= 100;
            pick_operands(value, modulus);
            send_operands(value, modulus);
        end

        @(negedge clk);
        operands_if.valid <= 1'b0;

        // Drain: wait for every predicted result, then give the block a full
        // item time in case it sends something it should not.
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("** modular_inverse: PASSED **");
        else
            $display("** modular_inverse: FAILED **");
        $finish;
    end

endmodule
